### rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, constants and the per-channel pair average for the mip level
// box downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

	localparam int PIXEL_W             = 32;
	localparam int DIM_W               = 12;
	localparam int ROW_W               = 11;
	localparam int HEIGHT_LIMIT        = 2048;
	localparam int DIM_RESET           = 2048;
	localparam int MAX_LEVEL_WIDTH_DEF = 2048;
	localparam int CFG_INDEX_W         = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1
	} cfg_reg_t;

	// per-beat control from the scan logic
	typedef struct packed {
		logic wr;        // store the pair average in the line store
		logic mem_res;   // result is line store entry averaged with the pair
		logic pair_res;  // result is the pair average alone
		logic done;      // last pixel of the produced level
	} mbd_ctl_t;

	function automatic logic [PIXEL_W-1:0] avg_pair(input logic [PIXEL_W-1:0] a,
		input logic [PIXEL_W-1:0] b);
		logic [PIXEL_W-1:0] r;
		logic [8:0]         s;
		r = '0;
		for (int i = 0; i < PIXEL_W / 8; i++) begin
			s = {1'b0, a[i*8 +: 8]} + {1'b0, b[i*8 +: 8]};
			r[i*8 +: 8] = s[8:1];
		end
		return r;
	endfunction

endpackage

### rtl/mbd_line_store.sv
// ----------------------------------------------------------------------------
// mbd_line_store
// Line store of horizontal pair averages from the even row; one write port,
// one registered read port.
// ----------------------------------------------------------------------------
module mbd_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

### rtl/mbd_scan.sv
// ----------------------------------------------------------------------------
// mbd_scan
// Size registers, column/row counters, held first pixel of each pair and the pair average;
// decodes what each accepted beat does.
// ----------------------------------------------------------------------------
module mbd_scan #(
	parameter int MAX_LEVEL_WIDTH = mbd_pkg::MAX_LEVEL_WIDTH_DEF,
	parameter int LINE_DEPTH      = mbd_pkg::MAX_LEVEL_WIDTH_DEF / 2,
	parameter int AW              = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mbd_pkg::DIM_W-1:0]        cfg_wdata,
	input  logic                             accept,
	input  logic [mbd_pkg::PIXEL_W-1:0]      source_pixel,
	output mbd_pkg::mbd_ctl_t                ctl,
	output logic [AW-1:0]                    line_addr,
	output logic [mbd_pkg::PIXEL_W-1:0]      pair_avg
);
	import mbd_pkg::*;

	localparam int WCAP = (MAX_LEVEL_WIDTH < (1 << DIM_W) - 1) ?
		MAX_LEVEL_WIDTH : (1 << DIM_W) - 1;
	localparam int CW   = ($clog2(WCAP) < 2) ? 2 : $clog2(WCAP);

	logic [DIM_W-1:0]   width_q, height_q;
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [DIM_W-1:0]   w_half_m1, h_half_m1;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PIXEL_W-1:0] held_q;
	logic [DIM_W:0]     col_next, row_next;
	logic               col_wrap, row_wrap;
	logic [CW-2:0]      idx;
	logic               in_range;
	logic               m2d, mcol, mrow;
	logic               c_odd, r_odd;
	logic               cidx_last, ridx_last;

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(WCAP)) begin
			w_eff = DIM_W'(WCAP);
		end
		h_eff = height_q;
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(HEIGHT_LIMIT)) begin
			h_eff = DIM_W'(HEIGHT_LIMIT);
		end
	end

	assign w_half_m1 = (w_eff >> 1) - DIM_W'(1);
	assign h_half_m1 = (h_eff >> 1) - DIM_W'(1);

	assign col_next = (DIM_W + 1)'(col_q) + (DIM_W + 1)'(1);
	assign row_next = (DIM_W + 1)'(row_q) + (DIM_W + 1)'(1);
	assign col_wrap = col_next >= {1'b0, w_eff};
	assign row_wrap = row_next >= {1'b0, h_eff};

	assign idx      = col_q[CW-1:1];
	assign in_range = int'(idx) < LINE_DEPTH;
	assign line_addr = AW'(idx);

	assign c_odd = col_q[0];
	assign r_odd = row_q[0];
	assign m2d   = (w_eff >= DIM_W'(2)) && (h_eff >= DIM_W'(2));
	assign mcol  = (w_eff == DIM_W'(1)) && (h_eff >= DIM_W'(2));
	assign mrow  = (h_eff == DIM_W'(1)) && (w_eff >= DIM_W'(2));

	assign cidx_last = DIM_W'(idx) == w_half_m1;
	assign ridx_last = DIM_W'(row_q[ROW_W-1:1]) == h_half_m1;

	assign pair_avg = avg_pair(held_q, source_pixel);

	always_comb begin
		ctl.wr       = m2d && c_odd && !r_odd && in_range;
		ctl.mem_res  = m2d && c_odd && r_odd && in_range;
		ctl.pair_res = (mcol && r_odd) || (mrow && c_odd);
		if (m2d) begin
			ctl.done = cidx_last && ridx_last;
		end else if (mcol) begin
			ctl.done = ridx_last;
		end else begin
			ctl.done = cidx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(DIM_RESET);
			height_q <= DIM_W'(DIM_RESET);
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH: begin
					width_q <= cfg_wdata;
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_SOURCE_HEIGHT: begin
					height_q <= cfg_wdata;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (((m2d || mrow) && !c_odd) || (mcol && !r_odd)) begin
				held_q <= source_pixel;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_col_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W + 1)'(col_q) < {1'b0, w_eff})
		else $error("column counter beyond level width");
	a_row_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W + 1)'(row_q) < {1'b0, h_eff})
		else $error("row counter beyond level height");
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.wr, ctl.mem_res, ctl.pair_res}))
		else $error("beat decoded to more than one action");
`endif

endmodule

### rtl/mbd_reduce.sv
// ----------------------------------------------------------------------------
// mbd_reduce
// Stage register beside the line store read and the result register with the
// final vertical average or the pair average alone.
// ----------------------------------------------------------------------------
module mbd_reduce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        accept,
	input  mbd_pkg::mbd_ctl_t           ctl,
	input  logic [mbd_pkg::PIXEL_W-1:0] pair_avg,
	input  logic [mbd_pkg::PIXEL_W-1:0] line_data,
	output logic                        result_valid,
	output logic [mbd_pkg::PIXEL_W-1:0] reduced_pixel,
	output logic                        level_done
);
	import mbd_pkg::*;

	logic               valid_s1, mem_res_s1, done_s1;
	logic [PIXEL_W-1:0] pair_s1;
	logic [PIXEL_W-1:0] result;
	logic               valid_q, done_q;
	logic [PIXEL_W-1:0] pixel_q;

	assign result = mem_res_s1 ? avg_pair(line_data, pair_s1) : pair_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && (ctl.mem_res || ctl.pair_res);
			valid_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mem_res_s1 <= ctl.mem_res;
			done_s1    <= ctl.done;
			pair_s1    <= pair_avg;
			pixel_q    <= result;
			done_q     <= done_s1;
		end
	end

	assign result_valid  = valid_q;
	assign reduced_pixel = pixel_q;
	assign level_done    = done_q;

`ifndef SYNTHESIS
	a_result_enters: assert property (@(posedge clk) disable iff (!arst_n)
		en && accept && (ctl.mem_res || ctl.pair_res) |=> valid_s1)
		else $error("result beat lost entering stage 1");
	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 |=> valid_q)
		else $error("result beat lost leaving stage 1");
`endif

endmodule

### rtl/mipmap_box_downsampler_core.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsampler_core
// Takes one RGBA8 mip level in raster order and produces the next, half-size
// level with a 2x2 box filter (pair averages for one-wide or one-high levels).
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------
//   source   | source_valid / source_stall | source_pixel
//   result   | result_valid / result_stall | reduced_pixel, level_done
//   config   | cfg_we                      | cfg_index, cfg_wdata
//
// One pixel beat per cycle while the result is not stalled; a result passes the
// registered line store read (beside the stage register) and then the result
// register. No clearing pass after reset. A stalled result freezes both
// stages and stalls the source in the same cycle.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler_core #(
	parameter int MAX_LEVEL_WIDTH = mbd_pkg::MAX_LEVEL_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            source_valid,
	output logic                            source_stall,
	input  logic [mbd_pkg::PIXEL_W-1:0]     source_pixel,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [mbd_pkg::PIXEL_W-1:0]     reduced_pixel,
	output logic                            level_done,
	input  logic                            cfg_we,
	input  logic [mbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbd_pkg::DIM_W-1:0]       cfg_wdata
);
	import mbd_pkg::*;

	localparam int LINE_DEPTH = MAX_LEVEL_WIDTH / 2;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic               en, accept;
	mbd_ctl_t           ctl;
	logic [AW-1:0]      line_addr;
	logic [PIXEL_W-1:0] pair_avg;
	logic [PIXEL_W-1:0] line_data;

	assign en           = !(result_valid && result_stall);
	assign source_stall = !en;
	assign accept       = source_valid && en;

	mbd_scan #(
		.MAX_LEVEL_WIDTH (MAX_LEVEL_WIDTH),
		.LINE_DEPTH      (LINE_DEPTH),
		.AW              (AW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.source_pixel (source_pixel),
		.ctl          (ctl),
		.line_addr    (line_addr),
		.pair_avg     (pair_avg)
	);

	mbd_line_store #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW),
		.DW    (PIXEL_W)
	) u_line_store (
		.clk     (clk),
		.wr_en   (accept && ctl.wr),
		.wr_addr (line_addr),
		.wr_data (pair_avg),
		.rd_en   (en),
		.rd_addr (line_addr),
		.rd_data (line_data)
	);

	mbd_reduce u_reduce (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.accept        (accept),
		.ctl           (ctl),
		.pair_avg      (pair_avg),
		.line_data     (line_data),
		.result_valid  (result_valid),
		.reduced_pixel (reduced_pixel),
		.level_done    (level_done)
	);

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mipmap_box_downsampler_core. An in-bench predictor
// rebuilds each half-size level from the accepted source beats: 2x2 box
// averages, vertical or horizontal pairs for one-wide or one-high levels.
// Every result beat is compared with the oldest predicted pixel. Covers reset
// sizes, size extremes, odd and zero sizes, level restart on register writes,
// level wrap, random levels under bursty sources and patterned result stalls,
// and a long result hold-off that backs up into the source.
// ----------------------------------------------------------------------------
module tb_top;
	import mbd_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 600000;
	localparam int unsigned RANDOM_BEATS = 800;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned LINE_WORDS   = MAX_LEVEL_WIDTH_DEF / 2;
	// indexes past the two size registers are ignored by the block
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [PIXEL_W-1:0] pix;
		logic               done;
	} reduced_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   source_valid = 1'b0;
	logic                   source_stall;
	logic [PIXEL_W-1:0]     source_pixel = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [PIXEL_W-1:0]     reduced_pixel;
	logic                   level_done;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]       cfg_wdata = '0;

	// predictor state
	logic [DIM_W-1:0]   size_w;
	logic [DIM_W-1:0]   size_h;
	logic [PIXEL_W-1:0] pair_line [LINE_WORDS];
	logic [PIXEL_W-1:0] held_pix;
	int unsigned        col_pos;
	int unsigned        row_pos;
	reduced_t           reduced_q [$];

	int unsigned cycle_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned beat_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned setting_cnt = 0;
	int unsigned burst_left = 0;
	int unsigned gap_max = 4;
	int unsigned burst_max = 12;
	int unsigned hold_req = 0;

	mipmap_box_downsampler_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_valid (source_valid),
		.source_stall (source_stall),
		.source_pixel (source_pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.reduced_pixel(reduced_pixel),
		.level_done   (level_done),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				reduced_q.size());
			$display("mipmap_box_downsampler_core verification failed");
			$finish;
		end
	end

	function automatic logic [PIXEL_W-1:0] byte_mean(input logic [PIXEL_W-1:0] a,
		input logic [PIXEL_W-1:0] b);
		logic [PIXEL_W-1:0] m;
		logic [8:0]         sum;
		m = '0;
		for (int i = 0; i < PIXEL_W / 8; i++) begin
			sum = {1'b0, a[i*8 +: 8]} + {1'b0, b[i*8 +: 8]};
			m[i*8 +: 8] = sum[8:1];
		end
		return m;
	endfunction

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned cap);
		if (v == 0)
			return 1;
		if (v > cap)
			return cap;
		return 32'(v);
	endfunction

	task automatic predict_reset();
		size_w = DIM_W'(DIM_RESET);
		size_h = DIM_W'(DIM_RESET);
		held_pix = '0;
		col_pos = 0;
		row_pos = 0;
		foreach (pair_line[i])
			pair_line[i] = '0;
	endtask

	task automatic predict_beat(input logic [PIXEL_W-1:0] px);
		int unsigned        w;
		int unsigned        h;
		int unsigned        idx;
		logic [PIXEL_W-1:0] pair;
		reduced_t           want;
		bit                 emit;
		w = eff_dim(size_w, MAX_LEVEL_WIDTH_DEF);
		h = eff_dim(size_h, HEIGHT_LIMIT);
		emit = 1'b0;
		want = '0;
		idx = col_pos >> 1;
		if (w >= 2 && h >= 2) begin
			if (col_pos[0] == 1'b0) begin
				held_pix = px;
			end else begin
				pair = byte_mean(held_pix, px);
				if (row_pos[0] == 1'b0) begin
					pair_line[idx] = pair;
				end else begin
					want.pix = byte_mean(pair_line[idx], pair);
					want.done = (idx == w / 2 - 1) && ((row_pos >> 1) == h / 2 - 1);
					emit = 1'b1;
				end
			end
		end else if (w == 1 && h >= 2) begin
			if (row_pos[0] == 1'b0) begin
				held_pix = px;
			end else begin
				want.pix = byte_mean(held_pix, px);
				want.done = (row_pos >> 1) == h / 2 - 1;
				emit = 1'b1;
			end
		end else if (h == 1 && w >= 2) begin
			if (col_pos[0] == 1'b0) begin
				held_pix = px;
			end else begin
				want.pix = byte_mean(held_pix, px);
				want.done = idx == w / 2 - 1;
				emit = 1'b1;
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
		if (emit)
			reduced_q.push_back(want);
	endtask

	always @(posedge clk) begin
		reduced_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (reduced_q.size() == 0) begin
				$error("unexpected result beat: reduced_pixel %h level_done %b",
					reduced_pixel, level_done);
				err_cnt++;
			end else begin
				want = reduced_q.pop_front();
				result_cnt++;
				if (reduced_pixel !== want.pix) begin
					$error("reduced_pixel: expected %h, got %h", want.pix, reduced_pixel);
					err_cnt++;
				end
				if (level_done !== want.done) begin
					$error("level_done: expected %b, got %b", want.done, level_done);
					err_cnt++;
				end
			end
		end
	end

	// result stall pattern; a long hold-off takes priority when requested
	initial begin : recv_pattern
		int unsigned seg;
		int unsigned mode;
		int unsigned per;
		int unsigned duty;
		forever begin
			seg = $urandom_range(16, 160);
			mode = $urandom_range(0, 3);
			per = $urandom_range(2, 7);
			duty = $urandom_range(1, per - 1);
			for (int unsigned k = 0; k < seg; k++) begin
				@(posedge clk);
				if (hold_req != 0) begin
					result_stall <= 1'b1;
					repeat (hold_req) @(posedge clk);
					hold_req = 0;
				end
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= ((k % per) < duty);
				endcase
			end
		end
	end

	task automatic send_pixel(input logic [PIXEL_W-1:0] px);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				source_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, burst_max);
		end
		source_valid <= 1'b1;
		source_pixel <= px;
		@(posedge clk);
		while (source_stall)
			@(posedge clk);
		predict_beat(px);
		burst_left--;
		beat_cnt++;
	endtask

	task automatic stop_source();
		source_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		stop_source();
		while (reduced_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOURCE_WIDTH) begin
			size_w = val;
			col_pos = 0;
			row_pos = 0;
		end else if (idx == REG_SOURCE_HEIGHT) begin
			size_h = val;
			col_pos = 0;
			row_pos = 0;
		end
		@(posedge clk);
	endtask

	task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(REG_SOURCE_WIDTH, w);
		write_reg(REG_SOURCE_HEIGHT, h);
		setting_cnt++;
	endtask

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		logic [PIXEL_W-1:0] px;
		px = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < PIXEL_W / 8; i++) begin
				case ($urandom_range(0, 4))
					0: px[i*8 +: 8] = 8'h00;
					1: px[i*8 +: 8] = 8'hff;
					2: px[i*8 +: 8] = 8'h01;
					3: px[i*8 +: 8] = 8'hfe;
					default: ;
				endcase
			end
		end
		return px;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return DIM_W'($urandom_range(1, 16));
		if (r < 82)
			return DIM_W'(1 << $urandom_range(0, 6));
		if (r < 88)
			return '0;
		if (r < 94)
			return $urandom_range(0, 1) ? 12'hfff : DIM_W'($urandom_range(2049, 4095));
		return DIM_W'($urandom_range(17, 200));
	endfunction

	task automatic send_random(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_pixel(pick_pixel());
	endtask

	// reset sizes are 2048x2048: a short run stays in the first row, so no result
	task automatic test_reset_size();
		setting_cnt++;
		send_random(16);
		wait_idle();
	endtask

	task automatic test_box_2x2();
		set_size(2, 2);
		send_pixel(32'h00000000);
		send_pixel(32'hffffffff);
		send_pixel(32'hff00ff00);
		send_pixel(32'h00ff00ff);
		// second level after wrap: truncation of odd sums
		send_pixel(32'h01010101);
		send_pixel(32'h00000000);
		send_pixel(32'hfefefefe);
		send_pixel(32'hffffffff);
		wait_idle();
	endtask

	task automatic test_degenerate_sizes();
		// zero width acts as one: vertical pairs
		set_size(0, 2);
		send_pixel(32'hffffffff);
		send_pixel(32'h80808080);
		wait_idle();
		// one by one: beats taken, nothing produced
		set_size(1, 0);
		send_pixel(32'h12345678);
		send_pixel(32'hffffffff);
		wait_idle();
		// odd width, one high: last column unpaired
		set_size(3, 1);
		send_pixel(32'h7f7f7f7f);
		send_pixel(32'h80808080);
		send_pixel(32'hdeadbeef);
		wait_idle();
	endtask

	task automatic test_restart();
		set_size(4, 2);
		send_pixel(32'h11223344);
		send_pixel(32'h55667788);
		send_pixel(32'h99aabbcc);
		wait_idle();
		// spare indexes must not restart the level
		write_reg(REG_SPARE_2, 12'hfff);
		write_reg(REG_SPARE_3, 12'h000);
		send_pixel(32'hddeeff00);
		wait_idle();
		write_reg(REG_SOURCE_WIDTH, 4);
		send_random(8);
		wait_idle();
	endtask

	task automatic test_size_extremes();
		set_size(12'hfff, 1);
		send_random(80);
		wait_idle();
		set_size(DIM_W'(MAX_LEVEL_WIDTH_DEF), 2);
		send_random(80);
		wait_idle();
		set_size(1, 12'hfff);
		send_random(40);
		wait_idle();
		set_size(1, DIM_W'(HEIGHT_LIMIT));
		send_random(40);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_size(2, 2);
		gap_max = 0;
		hold_req = 400;
		send_random(80);
		wait_idle();
		gap_max = 4;
	endtask

	task automatic test_random_levels();
		int unsigned counted;
		int unsigned area;
		int unsigned n;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			w = pick_dim();
			h = pick_dim();
			case ($urandom_range(0, 3))
				0: write_reg(REG_SOURCE_WIDTH, w);
				1: write_reg(REG_SOURCE_HEIGHT, h);
				default: begin
					write_reg(REG_SOURCE_WIDTH, w);
					write_reg(REG_SOURCE_HEIGHT, h);
				end
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, DIM_W'($urandom));
			setting_cnt++;
			area = eff_dim(size_w, MAX_LEVEL_WIDTH_DEF) * eff_dim(size_h, HEIGHT_LIMIT);
			if (area * 2 <= 300 && $urandom_range(0, 9) < 7)
				n = area * $urandom_range(1, 2);
			else
				n = $urandom_range(1, (area * 2 < 300) ? area * 2 : 300);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_max = $urandom_range(1, 16);
			burst_left = 0;
			send_random(n);
			if (area > 1)
				counted += n;
			wait_idle();
		end
	endtask

	initial begin
		predict_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_box_2x2();
		test_degenerate_sizes();
		test_restart();
		test_size_extremes();
		test_backpressure();
		test_random_levels();
		wait_idle();
		$display("covered %0d source beats over %0d size settings, %0d reduced pixels checked",
			beat_cnt, setting_cnt, result_cnt);
		$display("incl. 1x1, zero, odd and oversize levels, restarts and a long result hold-off");
		if (err_cnt == 0) begin
			$display("mipmap_box_downsampler_core verification clean");
		end else begin
			$display("mipmap_box_downsampler_core verification failed");
		end
		$finish;
	end

endmodule
